>>> rtl/slx_pkg.sv
// ----------------------------------------------------------------------
// slx_pkg
// Shared widths, token kinds and record types of the source lexer.
// ----------------------------------------------------------------------
package slx_pkg;

  localparam int unsigned KIND_W = 5;
  localparam int unsigned POS_W  = 32;
  localparam int unsigned LINE_W = 24;
  localparam int unsigned VAL_W  = 63;

  // tokens one input beat can give, and the count field that holds it
  localparam int unsigned SLOTS = 3;
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam int unsigned IDX_W = $clog2(SLOTS);

  // record queue between front and back end
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam logic [KIND_W-1:0] K_LPAREN     = 5'd0;
  localparam logic [KIND_W-1:0] K_RPAREN     = 5'd1;
  localparam logic [KIND_W-1:0] K_LBRACE     = 5'd2;
  localparam logic [KIND_W-1:0] K_RBRACE     = 5'd3;
  localparam logic [KIND_W-1:0] K_COMMA      = 5'd4;
  localparam logic [KIND_W-1:0] K_DOT        = 5'd5;
  localparam logic [KIND_W-1:0] K_SEMI       = 5'd6;
  localparam logic [KIND_W-1:0] K_MINUS      = 5'd7;
  localparam logic [KIND_W-1:0] K_PLUS       = 5'd8;
  localparam logic [KIND_W-1:0] K_STAR       = 5'd9;
  localparam logic [KIND_W-1:0] K_SLASH      = 5'd10;
  localparam logic [KIND_W-1:0] K_BANG       = 5'd11;
  localparam logic [KIND_W-1:0] K_BANG_EQ    = 5'd12;
  localparam logic [KIND_W-1:0] K_EQUAL      = 5'd13;
  localparam logic [KIND_W-1:0] K_EQ_EQ      = 5'd14;
  localparam logic [KIND_W-1:0] K_LESS       = 5'd15;
  localparam logic [KIND_W-1:0] K_LESS_EQ    = 5'd16;
  localparam logic [KIND_W-1:0] K_GREATER    = 5'd17;
  localparam logic [KIND_W-1:0] K_GREATER_EQ = 5'd18;
  localparam logic [KIND_W-1:0] K_AND        = 5'd19;
  localparam logic [KIND_W-1:0] K_OR         = 5'd20;
  localparam logic [KIND_W-1:0] K_NUMBER     = 5'd21;
  localparam logic [KIND_W-1:0] K_IDENT      = 5'd22;
  localparam logic [KIND_W-1:0] K_END        = 5'd23;
  localparam logic [KIND_W-1:0] K_ERROR      = 5'd24;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  start;
    logic [POS_W-1:0]  len;
    logic [VAL_W-1:0]  value;
    logic              is_float;
  } tok_t;

  // all tokens of one input beat share the line counter
  typedef struct packed {
    logic [CNT_W-1:0]      count;
    logic [LINE_W-1:0]     line;
    tok_t [SLOTS-1:0]      tok;
  } rec_t;

endpackage

>>> rtl/slx_front.sv
// ----------------------------------------------------------------------
// slx_front
// Scanner state machine: takes one beat per cycle while accept_i is high
// and builds a record of up to three tokens for it.
// ----------------------------------------------------------------------
module slx_front import slx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic       command_i,
  input  logic [7:0] source_byte_i,
  output logic       rec_valid_o,
  output rec_t       rec_o
);

  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_LESS    = 8'h3C;
  localparam logic [7:0] CH_GREATER = 8'h3E;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_BAR     = 8'h7C;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOW_A   = 8'h61;
  localparam logic [7:0] CH_LOW_Z   = 8'h7A;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_Z    = 8'h5A;
  localparam logic [7:0] CH_UNDER   = 8'h5F;

  localparam logic [POS_W-1:0]  POS_MAX  = '1;
  localparam logic [LINE_W-1:0] LINE_MAX = '1;
  localparam logic [VAL_W-1:0]  VAL_MAX  = '1;
  localparam int unsigned       PROD_W   = VAL_W + 4;

  typedef enum logic [6:0] {
    M_IDLE    = 7'b0000001,
    M_OP      = 7'b0000010,
    M_COMMENT = 7'b0000100,
    M_IDENT   = 7'b0001000,
    M_NUMBER  = 7'b0010000,
    M_NUMDOT  = 7'b0100000,
    M_FRAC    = 7'b1000000
  } mode_e;

  typedef enum logic [2:0] {
    P_NONE    = 3'd0,
    P_BANG    = 3'd1,
    P_EQUAL   = 3'd2,
    P_LESS    = 3'd3,
    P_GREATER = 3'd4,
    P_SLASH   = 3'd5,
    P_AMP     = 3'd6,
    P_BAR     = 3'd7
  } pend_e;

  function automatic tok_t mk_tok(logic [KIND_W-1:0] kind, logic [POS_W-1:0] start,
                                  logic [POS_W-1:0] len, logic [VAL_W-1:0] value,
                                  logic is_float);
    tok_t t;
    t.kind     = kind;
    t.start    = start;
    t.len      = len;
    t.value    = value;
    t.is_float = is_float;
    return t;
  endfunction

  // one-byte form of a waiting operator; lone & and | are errors
  function automatic logic [KIND_W-1:0] single_kind(pend_e p);
    logic [KIND_W-1:0] k;
    case (p)
      P_BANG:    k = K_BANG;
      P_EQUAL:   k = K_EQUAL;
      P_LESS:    k = K_LESS;
      P_GREATER: k = K_GREATER;
      P_SLASH:   k = K_SLASH;
      default:   k = K_ERROR;
    endcase
    return k;
  endfunction

  function automatic logic [KIND_W-1:0] eq_kind(pend_e p);
    logic [KIND_W-1:0] k;
    case (p)
      P_BANG:  k = K_BANG_EQ;
      P_EQUAL: k = K_EQ_EQ;
      P_LESS:  k = K_LESS_EQ;
      default: k = K_GREATER_EQ;
    endcase
    return k;
  endfunction

  mode_e             mode_q, mode_d;
  pend_e             pend_q, pend_d;
  logic [POS_W-1:0]  start_q, start_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [LINE_W-1:0] line_q, line_d;
  logic [VAL_W-1:0]  acc_q, acc_d;
  logic              frac_q, frac_d;

  tok_t [SLOTS-1:0]  tok;
  logic [CNT_W-1:0]  cnt;
  logic              rescan;
  logic [POS_W-1:0]  span, span_m1, dot_at;
  logic [VAL_W-1:0]  num_val;
  logic [PROD_W-1:0] acc_x10;
  logic              b_digit, b_alpha;
  logic [7:0]        b;

  assign b       = source_byte_i;
  assign b_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign b_alpha = ((b >= CH_LOW_A) && (b <= CH_LOW_Z)) ||
                   ((b >= CH_UP_A) && (b <= CH_UP_Z)) || (b == CH_UNDER);

  assign span    = (pos_q >= start_q) ? pos_q - start_q : '0;
  assign span_m1 = (span != '0) ? span - POS_W'(1) : '0;
  assign dot_at  = (pos_q != '0) ? pos_q - POS_W'(1) : '0;
  assign num_val = frac_q ? '0 : acc_q;
  // acc * 10 + digit, low nibble of an ascii digit is its value
  assign acc_x10 = PROD_W'({acc_q, 3'b000}) + PROD_W'({acc_q, 1'b0}) + PROD_W'(b[3:0]);

  always_comb begin
    mode_d  = mode_q;
    pend_d  = pend_q;
    start_d = start_q;
    pos_d   = pos_q;
    line_d  = line_q;
    acc_d   = acc_q;
    frac_d  = frac_q;
    tok     = '0;
    cnt     = '0;
    rescan  = 1'b0;

    if (accept_i) begin
      if (command_i == CMD_END) begin
        // flush whatever is waiting, then END
        case (mode_q)
          M_OP: begin
            tok[0] = mk_tok(single_kind(pend_q), start_q, POS_W'(1), '0, 1'b0);
            cnt    = CNT_W'(1);
          end
          M_IDENT: begin
            tok[0] = mk_tok(K_IDENT, start_q, span, '0, 1'b0);
            cnt    = CNT_W'(1);
          end
          M_NUMBER, M_FRAC: begin
            tok[0] = mk_tok(K_NUMBER, start_q, span, num_val, frac_q);
            cnt    = CNT_W'(1);
          end
          M_NUMDOT: begin
            tok[0] = mk_tok(K_NUMBER, start_q, span_m1, num_val, frac_q);
            tok[1] = mk_tok(K_DOT, dot_at, POS_W'(1), '0, 1'b0);
            cnt    = CNT_W'(2);
          end
          default: begin
            cnt = '0;
          end
        endcase
        tok[cnt[IDX_W-1:0]] = mk_tok(K_END, pos_q, '0, '0, 1'b0);
        cnt     = cnt + CNT_W'(1);
        mode_d  = M_IDLE;
        pend_d  = P_NONE;
        start_d = '0;
        pos_d   = '0;
        line_d  = '0;
        acc_d   = '0;
        frac_d  = 1'b0;
      end else begin
        // settle the waiting token against this byte
        case (mode_q)
          M_OP: begin
            mode_d = M_IDLE;
            pend_d = P_NONE;
            if ((pend_q == P_BANG || pend_q == P_EQUAL || pend_q == P_LESS ||
                 pend_q == P_GREATER) && b == CH_EQUAL) begin
              tok[0] = mk_tok(eq_kind(pend_q), start_q, POS_W'(2), '0, 1'b0);
              cnt    = CNT_W'(1);
            end else if (pend_q == P_SLASH && b == CH_SLASH) begin
              mode_d = M_COMMENT;
            end else if (pend_q == P_AMP && b == CH_AMP) begin
              tok[0] = mk_tok(K_AND, start_q, POS_W'(2), '0, 1'b0);
              cnt    = CNT_W'(1);
            end else if (pend_q == P_BAR && b == CH_BAR) begin
              tok[0] = mk_tok(K_OR, start_q, POS_W'(2), '0, 1'b0);
              cnt    = CNT_W'(1);
            end else begin
              tok[0] = mk_tok(single_kind(pend_q), start_q, POS_W'(1), '0, 1'b0);
              cnt    = CNT_W'(1);
              rescan = 1'b1;
            end
          end
          M_COMMENT: begin
            if (b == CH_LF) begin
              mode_d = M_IDLE;
              pend_d = P_NONE;
              rescan = 1'b1;
            end
          end
          M_IDENT: begin
            if (!(b_alpha || b_digit)) begin
              tok[0] = mk_tok(K_IDENT, start_q, span, '0, 1'b0);
              cnt    = CNT_W'(1);
              mode_d = M_IDLE;
              pend_d = P_NONE;
              rescan = 1'b1;
            end
          end
          M_NUMBER: begin
            if (b_digit) begin
              acc_d = (acc_x10[PROD_W-1:VAL_W] != '0) ? VAL_MAX : acc_x10[VAL_W-1:0];
            end else if (b == CH_DOT) begin
              mode_d = M_NUMDOT;
            end else begin
              tok[0] = mk_tok(K_NUMBER, start_q, span, num_val, frac_q);
              cnt    = CNT_W'(1);
              mode_d = M_IDLE;
              pend_d = P_NONE;
              rescan = 1'b1;
            end
          end
          M_NUMDOT: begin
            if (b_digit) begin
              frac_d = 1'b1;
              mode_d = M_FRAC;
            end else begin
              // number without the dot, then the dot on its own
              tok[0] = mk_tok(K_NUMBER, start_q, span_m1, num_val, frac_q);
              tok[1] = mk_tok(K_DOT, dot_at, POS_W'(1), '0, 1'b0);
              cnt    = CNT_W'(2);
              mode_d = M_IDLE;
              pend_d = P_NONE;
              rescan = 1'b1;
            end
          end
          M_FRAC: begin
            if (!b_digit) begin
              tok[0] = mk_tok(K_NUMBER, start_q, span, num_val, frac_q);
              cnt    = CNT_W'(1);
              mode_d = M_IDLE;
              pend_d = P_NONE;
              rescan = 1'b1;
            end
          end
          default: begin
            mode_d = M_IDLE;
            pend_d = P_NONE;
            rescan = 1'b1;
          end
        endcase

        if (rescan) begin
          case (b)
            CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_COMMA, CH_DOT,
            CH_SEMI, CH_MINUS, CH_PLUS, CH_STAR: begin
              case (b)
                CH_LPAREN: tok[cnt[IDX_W-1:0]] = mk_tok(K_LPAREN, pos_q, POS_W'(1), '0, 1'b0);
                CH_RPAREN: tok[cnt[IDX_W-1:0]] = mk_tok(K_RPAREN, pos_q, POS_W'(1), '0, 1'b0);
                CH_LBRACE: tok[cnt[IDX_W-1:0]] = mk_tok(K_LBRACE, pos_q, POS_W'(1), '0, 1'b0);
                CH_RBRACE: tok[cnt[IDX_W-1:0]] = mk_tok(K_RBRACE, pos_q, POS_W'(1), '0, 1'b0);
                CH_COMMA:  tok[cnt[IDX_W-1:0]] = mk_tok(K_COMMA, pos_q, POS_W'(1), '0, 1'b0);
                CH_DOT:    tok[cnt[IDX_W-1:0]] = mk_tok(K_DOT, pos_q, POS_W'(1), '0, 1'b0);
                CH_SEMI:   tok[cnt[IDX_W-1:0]] = mk_tok(K_SEMI, pos_q, POS_W'(1), '0, 1'b0);
                CH_MINUS:  tok[cnt[IDX_W-1:0]] = mk_tok(K_MINUS, pos_q, POS_W'(1), '0, 1'b0);
                CH_PLUS:   tok[cnt[IDX_W-1:0]] = mk_tok(K_PLUS, pos_q, POS_W'(1), '0, 1'b0);
                default:   tok[cnt[IDX_W-1:0]] = mk_tok(K_STAR, pos_q, POS_W'(1), '0, 1'b0);
              endcase
              cnt = cnt + CNT_W'(1);
            end
            CH_BANG, CH_EQUAL, CH_LESS, CH_GREATER, CH_SLASH, CH_AMP, CH_BAR: begin
              mode_d  = M_OP;
              start_d = pos_q;
              case (b)
                CH_BANG:    pend_d = P_BANG;
                CH_EQUAL:   pend_d = P_EQUAL;
                CH_LESS:    pend_d = P_LESS;
                CH_GREATER: pend_d = P_GREATER;
                CH_SLASH:   pend_d = P_SLASH;
                CH_AMP:     pend_d = P_AMP;
                default:    pend_d = P_BAR;
              endcase
            end
            CH_SPACE, CH_CR, CH_TAB: begin
              mode_d = M_IDLE;
            end
            CH_LF: begin
              if (line_q != LINE_MAX) begin
                line_d = line_q + LINE_W'(1);
              end
            end
            default: begin
              if (b_digit) begin
                mode_d  = M_NUMBER;
                start_d = pos_q;
                acc_d   = VAL_W'(b[3:0]);
                frac_d  = 1'b0;
              end else if (b_alpha) begin
                mode_d  = M_IDENT;
                start_d = pos_q;
              end else begin
                tok[cnt[IDX_W-1:0]] = mk_tok(K_ERROR, pos_q, POS_W'(1), '0, 1'b0);
                cnt = cnt + CNT_W'(1);
              end
            end
          endcase
        end

        if (pos_q != POS_MAX) begin
          pos_d = pos_q + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      pend_q  <= P_NONE;
      start_q <= '0;
      pos_q   <= '0;
      line_q  <= '0;
      acc_q   <= '0;
      frac_q  <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      pend_q  <= pend_d;
      start_q <= start_d;
      pos_q   <= pos_d;
      line_q  <= line_d;
      acc_q   <= acc_d;
      frac_q  <= frac_d;
    end
  end

  assign rec_valid_o = accept_i && (cnt != '0);
  assign rec_o.count = cnt;
  assign rec_o.line  = line_q;
  assign rec_o.tok   = tok;

endmodule

>>> rtl/slx_queue.sv
// ----------------------------------------------------------------------
// slx_queue
// Short record queue that decouples the scanner from token delivery.
// ----------------------------------------------------------------------
module slx_queue import slx_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  rec_t rec_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output rec_t rec_o
);

  rec_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d;
  logic [QPTR_W-1:0] rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign rec_o   = mem_q[rd_q];

endmodule

>>> rtl/slx_back.sv
// ----------------------------------------------------------------------
// slx_back
// Token delivery: walks the tokens of the head record one per cycle into
// the output register while it is free or being drained.
// ----------------------------------------------------------------------
module slx_back import slx_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rec_valid_i,
  input  rec_t              rec_i,
  output logic              rec_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output tok_t              tok_o,
  output logic [LINE_W-1:0] line_o,
  output logic              last_o
);

  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              valid_q, valid_d;
  tok_t              tok_q;
  logic [LINE_W-1:0] line_q;
  logic              last_q;
  logic              load, last_slot;

  // output register takes a token when it is free or being drained
  assign load      = rec_valid_i && (!valid_q || pop_i);
  assign last_slot = (CNT_W'(idx_q) == rec_i.count - CNT_W'(1));
  assign rec_pop_o = load && last_slot;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      idx_d   = last_slot ? '0 : idx_q + IDX_W'(1);
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tok_q  <= rec_i.tok[idx_q];
      line_q <= rec_i.line;
      last_q <= last_slot;
    end
  end

  assign empty_o = !valid_q;
  assign tok_o   = tok_q;
  assign line_o  = line_q;
  assign last_o  = last_q;

endmodule

>>> rtl/source_code_lexer_unit.sv
// ----------------------------------------------------------------------
// source_code_lexer_unit
// Streaming lexer for a small C-like language. Source text goes in one
// beat per cycle while full is low (a byte, or an end-of-source command
// that flushes the pending token, emits END and restarts offsets and
// lines at zero). The scanner accepts such a beat every cycle and turns
// it into a record of up to three tokens, written into a four-record
// queue; the delivery side hands out one token per cycle from that queue
// while the output register is free or popped. The sustained rate is one
// beat per cycle as long as the tokens per beat average at most one;
// bursts are absorbed by the queue and full rises only when it holds
// four records. With the queue empty and the output register free, the
// first token of a beat reaches the ports via the queue memory and the
// output register. last_of_run_o marks the final token of each beat.
// ----------------------------------------------------------------------
module source_code_lexer_unit import slx_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic              command_i,
  input  logic [7:0]        source_byte_i,
  output logic              empty,
  input  logic              pop,
  output logic [KIND_W-1:0] token_kind_o,
  output logic [POS_W-1:0]  lexeme_start_o,
  output logic [POS_W-1:0]  lexeme_length_o,
  output logic [LINE_W-1:0] line_number_o,
  output logic [VAL_W-1:0]  integer_value_o,
  output logic              is_float_o,
  output logic              last_of_run_o
);

  logic accept;
  logic rec_push, rec_valid, rec_pop;
  logic q_full, out_empty;
  rec_t rec_in, rec_head;
  tok_t tok;

  assign accept = push && !q_full;

  slx_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .command_i     (command_i),
    .source_byte_i (source_byte_i),
    .rec_valid_o   (rec_push),
    .rec_o         (rec_in)
  );

  slx_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .rec_i   (rec_in),
    .full_o  (q_full),
    .pop_i   (rec_pop),
    .valid_o (rec_valid),
    .rec_o   (rec_head)
  );

  slx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (rec_valid),
    .rec_i       (rec_head),
    .rec_pop_o   (rec_pop),
    .pop_i       (pop && !out_empty),
    .empty_o     (out_empty),
    .tok_o       (tok),
    .line_o      (line_number_o),
    .last_o      (last_of_run_o)
  );

  assign full            = q_full;
  assign empty           = out_empty;
  assign token_kind_o    = tok.kind;
  assign lexeme_start_o  = tok.start;
  assign lexeme_length_o = tok.len;
  assign integer_value_o = tok.value;
  assign is_float_o      = tok.is_float;

endmodule
